[rtl/signed_leb128_stream_decoder_unit_defines.svh]
// Assertion helpers for the checker file of the decoder.
// Both macros expect clk and rst_n to exist in the scope where they are used.
`ifndef SIGNED_LEB128_STREAM_DECODER_UNIT_DEFINES_SVH
`define SIGNED_LEB128_STREAM_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SLEB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SLEB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sleb_pkg.sv]
`timescale 1ns / 1ps

package sleb_pkg;

    localparam int BYTE_W        = 8;
    localparam int DIGIT_W       = 7;
    localparam int CONT_BIT_POS  = 7;
    localparam int SIGN_BIT_POS  = 6;
    localparam int VALUE_W       = 32;
    localparam int NARROW_W      = 16;
    localparam int WIDE_W        = 32;
    localparam int SHIFT_W       = 6;
    localparam int CFG_DATA_W    = 32;
    localparam int CFG_IDX_W     = 1;
    localparam int COUNT_BITS_DEF = 32;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERLONG = 2'd1,
        ST_TRUNC    = 2'd2,
        ST_TRAIL    = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDE_MODE   = 1'b0,
        REG_VALUE_COUNT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } in_beat_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      value_valid;
        logic                      done_res;
        status_t                   status;
    } result_t;

endpackage

[rtl/sleb_channels.sv]
`timescale 1ns / 1ps

// Byte channel into the decoder.
interface sleb_byte_if;
    import sleb_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Result channel out of the decoder.
interface sleb_result_if;
    import sleb_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      value_valid;
    logic                      done_res;
    logic [1:0]                status;

    modport source (output valid, output value, output value_valid, output done_res,
                    output status, input ready);
    modport sink   (input valid, input value, input value_valid, input done_res,
                    input status, output ready);
endinterface

// Register write channel.
interface sleb_cfg_if;
    import sleb_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

[rtl/sleb_decode_core.sv]
`timescale 1ns / 1ps

module sleb_decode_core #(
    parameter int COUNT_BITS = sleb_pkg::COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                fire,
    input  sleb_pkg::in_beat_t                  beat,
    input  logic                                wide_mode,
    input  logic [sleb_pkg::CFG_DATA_W-1:0]     value_count,
    output logic                                res_valid,
    output sleb_pkg::result_t                   res
);
    import sleb_pkg::*;

    logic [VALUE_W-1:0]    partial_reg, partial_next;
    logic [SHIFT_W-1:0]    shift_reg, shift_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    status_t               error_reg, error_next;

    logic [SHIFT_W-1:0]             shift_lim;
    logic [SHIFT_W-1:0]             shift_inc;
    logic [VALUE_W+DIGIT_W-1:0]     digit_shifted;
    logic [VALUE_W-1:0]             merged;
    logic [VALUE_W-1:0]             v;
    logic                           have_value;
    status_t                        st;

    always_comb
    begin
        shift_lim     = wide_mode ? SHIFT_W'(WIDE_W) : SHIFT_W'(NARROW_W);
        shift_inc     = shift_reg + SHIFT_W'(DIGIT_W);
        digit_shifted = (VALUE_W+DIGIT_W)'(beat.data_byte[DIGIT_W-1:0]) << shift_reg;
        merged        = partial_reg | digit_shifted[VALUE_W-1:0];

        partial_next = partial_reg;
        shift_next   = shift_reg;
        count_next   = count_reg;
        error_next   = error_reg;
        have_value   = 1'b0;
        v            = merged;

        if (error_reg == ST_OK)
        begin
            if (CFG_DATA_W'(count_reg) >= value_count)
            begin
                error_next = ST_TRAIL;
            end
            else if (shift_reg >= shift_lim)
            begin
                error_next = ST_OVERLONG;
            end
            else
            begin
                partial_next = merged;
                shift_next   = shift_inc;
                if (!beat.data_byte[CONT_BIT_POS])
                begin
                    // Final byte of the value: sign-extend from the gathered bits.
                    if ((shift_inc < shift_lim) && beat.data_byte[SIGN_BIT_POS])
                    begin
                        v = merged | ({VALUE_W{1'b1}} << shift_inc);
                    end
                    if (!wide_mode)
                    begin
                        v = {{(VALUE_W-NARROW_W){v[NARROW_W-1]}}, v[NARROW_W-1:0]};
                    end
                    have_value   = 1'b1;
                    partial_next = '0;
                    shift_next   = '0;
                    if (!(&count_reg))
                    begin
                        count_next = count_reg + COUNT_BITS'(1);
                    end
                end
            end
        end

        priority if (error_next != ST_OK)
        begin
            st = error_next;
        end
        else if ((shift_next != '0) || (CFG_DATA_W'(count_next) < value_count))
        begin
            st = ST_TRUNC;
        end
        else
        begin
            st = ST_OK;
        end

        res_valid       = fire && (have_value || beat.last_byte);
        res.value       = have_value ? VALUE_W'(v) : '0;
        res.value_valid = have_value;
        res.done_res    = beat.last_byte;
        res.status      = beat.last_byte ? st : ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            shift_reg   <= '0;
            count_reg   <= '0;
            error_reg   <= ST_OK;
        end
        else if (fire)
        begin
            if (beat.last_byte)
            begin
                // End of blob: start the next one from a clean state.
                partial_reg <= '0;
                shift_reg   <= '0;
                count_reg   <= '0;
                error_reg   <= ST_OK;
            end
            else
            begin
                partial_reg <= partial_next;
                shift_reg   <= shift_next;
                count_reg   <= count_next;
                error_reg   <= error_next;
            end
        end
    end

endmodule

[rtl/sleb_out_buf.sv]
`timescale 1ns / 1ps

module sleb_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sleb_pkg::result_t push_data,
    output logic              full,
    sleb_result_if.source     result_ch
);
    import sleb_pkg::*;

    result_t     head_reg, head_next;
    result_t     tail_reg, tail_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        pop;

    always_comb
    begin
        pop       = result_ch.valid && result_ch.ready;
        full      = (cnt_reg == 2'd2);
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg + 2'(push) - 2'(pop);

        if (pop)
        begin
            if (cnt_reg == 2'd2)
            begin
                head_next = tail_reg;
            end
            else
            begin
                head_next = push_data;
            end
        end
        else if (cnt_reg == 2'd0)
        begin
            head_next = push_data;
        end

        if (push && (((cnt_reg == 2'd1) && !pop) || ((cnt_reg == 2'd2) && pop)))
        begin
            tail_next = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign result_ch.valid       = (cnt_reg != 2'd0);
    assign result_ch.value       = head_reg.value;
    assign result_ch.value_valid = head_reg.value_valid;
    assign result_ch.done_res    = head_reg.done_res;
    assign result_ch.status      = head_reg.status;

endmodule

[rtl/signed_leb128_stream_decoder_unit.sv]
// Path: an accepted byte is registered in stage one and decoded; its result, if any, is
// registered in the result queue, whose head drives the result channel.
// Throughput: one byte per cycle; the decode stage and the two-entry result queue
// let a new byte enter every cycle while the result side keeps taking beats.
// Reset (rst_n, asynchronous, active low) clears the decoder state, the register
// file (16-bit mode, value count zero) and all valid flags; no clearing pass is needed.
`timescale 1ns / 1ps

module signed_leb128_stream_decoder_unit #(
    parameter int COUNT_BITS = sleb_pkg::COUNT_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    sleb_byte_if.sink      byte_ch,
    sleb_result_if.source  result_ch,
    sleb_cfg_if.sink       cfg
);
    import sleb_pkg::*;

    // The block is a two-stage pipe. Stage one registers the incoming byte
    // beat. Stage two decodes it against the running value state and pushes
    // a result (when there is one) into a two-entry queue that drives the
    // result channel. Stage two only advances when the queue has room, so
    // no result can ever be dropped.

    logic       s1_valid_reg, s1_valid_next;
    in_beat_t   s1_beat_reg;
    logic       wide_mode_reg;
    logic [CFG_DATA_W-1:0] value_count_reg;

    logic       in_accept;
    logic       fire;
    logic       buf_full;
    logic       res_valid;
    result_t    res;

    // Registers always accept writes; the user must write only while idle (not enforced).
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_mode_reg   <= 1'b0;
            value_count_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_WIDE_MODE:   wide_mode_reg   <= cfg.wdata[0];
                REG_VALUE_COUNT: value_count_reg <= cfg.wdata;
                default:         ;
            endcase
        end
    end

    // Stage one moves on whenever the queue can take whatever the decode makes.
    assign fire          = s1_valid_reg && !buf_full;
    assign byte_ch.ready = !s1_valid_reg || fire;
    assign in_accept     = byte_ch.valid && byte_ch.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_beat_reg.data_byte <= byte_ch.data_byte;
            s1_beat_reg.last_byte <= byte_ch.last_byte;
        end
    end

    // Value assembly, sign extension, count and sticky error tracking.
    sleb_decode_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .beat        (s1_beat_reg),
        .wide_mode   (wide_mode_reg),
        .value_count (value_count_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    // Result queue: lets a finished result wait while the next byte decodes.
    sleb_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .full      (buf_full),
        .result_ch (result_ch)
    );

endmodule

[rtl/sleb_checker.sv]
`timescale 1ns / 1ps
`include "signed_leb128_stream_decoder_unit_defines.svh"

module sleb_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [sleb_pkg::VALUE_W-1:0] out_value,
    input logic                               out_value_valid,
    input logic                               out_done,
    input logic [1:0]                         out_status
);
    import sleb_pkg::*;

    logic stalled;

    assign stalled = out_valid && !out_ready;

    // A stalled result keeps its contents.
    `SLEB_ASSERT_NEXT(a_hold_val, stalled, out_valid && $stable(out_value), "held value changed")
    `SLEB_ASSERT_NEXT(a_hold_st, stalled, out_valid && $stable(out_status), "held status changed")

    // Every result carries a value, an end of blob, or both.
    `SLEB_ASSERT_NOW(a_nonempty, out_valid, out_value_valid || out_done, "empty result beat")

    // A result without a value reads as zero.
    `SLEB_ASSERT_NOW(a_zero, out_valid && !out_value_valid, out_value == '0, "value not zero")

    // Status is only reported on the end-of-blob result.
    `SLEB_ASSERT_NOW(a_status, out_valid && !out_done, out_status == ST_OK, "status outside done")

endmodule

bind signed_leb128_stream_decoder_unit sleb_checker u_sleb_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (result_ch.valid),
    .out_ready       (result_ch.ready),
    .out_value       (result_ch.value),
    .out_value_valid (result_ch.value_valid),
    .out_done        (result_ch.done_res),
    .out_status      (result_ch.status)
);
